// ===== sv/ipv4_fragmenter_ethernet_framer_defines.svh =====
// assertion macros for the ipv4 fragmenter and ethernet framer
// no dependencies; included by modules that carry assertions
`ifndef IPV4_FRAGMENTER_ETHERNET_FRAMER_DEFINES_SVH
`define IPV4_FRAGMENTER_ETHERNET_FRAMER_DEFINES_SVH
`ifndef ASSERT_OFF
`define IPFEF_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
	else $error("ipfef assertion failed");
`define IPFEF_ASSERT_NEXT(lbl, clk, rstn, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) pre |=> post) \
	else $error("ipfef assertion failed");
`else
`define IPFEF_ASSERT(lbl, clk, rstn, prop)
`define IPFEF_ASSERT_NEXT(lbl, clk, rstn, pre, post)
`endif
`endif

// ===== sv/ipfef_pkg.sv =====
// shared types and constants of the ipv4 fragmenter and ethernet framer
// no dependencies
`timescale 1ns / 1ps
package ipfef_pkg;
	localparam int unsigned MAX_DATAGRAM = 65535;
	localparam int unsigned IP_HDR_LEN   = 20;
	localparam int unsigned HDR_TOTAL    = 34;
	localparam int unsigned FIFO_DEPTH   = 4;
	localparam int unsigned FIFO_AW      = $clog2(FIFO_DEPTH);
	localparam int unsigned HDR_IDX_W    = $clog2(HDR_TOTAL);

	localparam logic [15:0] LEN_LIMIT = 16'(MAX_DATAGRAM - IP_HDR_LEN);
	localparam logic [10:0] MTU_MIN   = 11'd68;
	localparam logic [10:0] MTU_MAX   = 11'd1500;
	localparam logic [7:0]  TTL_VALUE = 8'd64;

	// register indexes
	localparam logic [2:0] REG_DEST_MAC = 3'd0;
	localparam logic [2:0] REG_SRC_MAC  = 3'd1;
	localparam logic [2:0] REG_SRC_IP   = 3'd2;
	localparam logic [2:0] REG_DEST_IP  = 3'd3;
	localparam logic [2:0] REG_MTU      = 3'd4;
	localparam logic [2:0] REG_IDENT    = 3'd5;

	// work item passed from front to back
	typedef struct packed {
		logic [7:0]  data;
		logic        last;
		logic        err;
		logic        hdr;
		logic        mf;
		logic [10:0] size;
		logic [12:0] offset;
		logic [7:0]  proto;
	} cmd_t;

	// addressing fields used by the header generator
	typedef struct packed {
		logic [47:0] dest_mac;
		logic [47:0] src_mac;
		logic [31:0] src_ip;
		logic [31:0] dest_ip;
		logic [15:0] ident;
	} hdr_cfg_t;
endpackage

// ===== sv/ipv4_fragmenter_ethernet_framer.sv =====
// top level: configuration registers, front end, queue and back end
// depends on ipfef_pkg, ipfef_front, ipfef_fifo, ipfef_back
//
//  channel | direction | beat contents
//  s_*     | in        | tdata: payload_byte, segment_length, upper_protocol; tuser: first_byte
//  m_*     | out       | tdata: frame_byte; tlast: frame_end; tuser: too_long
//  cfg_*   | in        | cfg_index register number, cfg_data value
//
// payload beats pass one per cycle unless m_tready stalls; the first beat of a fragment adds
// 34 header beats, during which the queue of four items fills and s_tready drops.
// the header generator in the back end sets the rate during header bursts.
// reset restores link_mtu 1500, ident 1 and other registers to zero.
// either side may stall independently; the queue and output register decouple them.
`timescale 1ns / 1ps
module ipv4_fragmenter_ethernet_framer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // payload_byte, segment_length, upper_protocol
	input  logic        s_tuser,  // first_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // frame_byte
	output logic        m_tlast,
	output logic        m_tuser,  // too_long
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [47:0] cfg_data
);
	import ipfef_pkg::*;

	hdr_cfg_t    hcfg_q;
	logic [10:0] mtu_q;
	logic        cmd_valid;
	logic        q_not_full;
	logic        q_not_empty;
	logic        q_pop;
	cmd_t        cmd;
	cmd_t        q_data;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hcfg_q <= '{dest_mac: '0, src_mac: '0, src_ip: '0, dest_ip: '0, ident: 16'd1};
			mtu_q  <= 11'd1500;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_DEST_MAC: hcfg_q.dest_mac <= cfg_data;
				REG_SRC_MAC:  hcfg_q.src_mac  <= cfg_data;
				REG_SRC_IP:   hcfg_q.src_ip   <= cfg_data[31:0];
				REG_DEST_IP:  hcfg_q.dest_ip  <= cfg_data[31:0];
				REG_MTU:      mtu_q           <= cfg_data[10:0];
				REG_IDENT:    hcfg_q.ident    <= cfg_data[15:0];
				default:      ;
			endcase
		end
	end

	ipfef_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (s_tvalid),
		.in_ready       (s_tready),
		.payload_byte   (s_tdata[7:0]),
		.first_byte     (s_tuser),
		.segment_length (s_tdata[23:8]),
		.upper_protocol (s_tdata[31:24]),
		.link_mtu       (mtu_q),
		.cmd_valid      (cmd_valid),
		.cmd_ready      (q_not_full),
		.cmd            (cmd)
	);

	ipfef_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (cmd_valid),
		.push_data (cmd),
		.not_full  (q_not_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.pop_data  (q_data)
	);

	ipfef_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.hcfg       (hcfg_q),
		.q_valid    (q_not_empty),
		.q_data     (q_data),
		.q_pop      (q_pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.frame_byte (m_tdata),
		.frame_end  (m_tlast),
		.too_long   (m_tuser)
	);
endmodule

// ===== sv/ipfef_front.sv =====
// front end: segment tracking and fragment classification of input beats
// depends on ipfef_pkg
`timescale 1ns / 1ps
module ipfef_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          payload_byte,
	input  logic                first_byte,
	input  logic [15:0]         segment_length,
	input  logic [7:0]          upper_protocol,
	input  logic [10:0]         link_mtu,
	output logic                cmd_valid,
	input  logic                cmd_ready,
	output ipfef_pkg::cmd_t     cmd
);
	import ipfef_pkg::*;

	logic [15:0] remain_q;
	logic [10:0] fill_q;
	logic [12:0] offset_q;
	logic [7:0]  proto_q;
	logic        drop_q;
	logic [10:0] fsize_q;

	logic [15:0] remain_d;
	logic [10:0] fill_d;
	logic [12:0] offset_d;
	logic [7:0]  proto_d;
	logic        drop_d;
	logic [10:0] fsize_d;
	logic        produce;
	logic        accept;
	logic [10:0] mtu_c;
	logic [10:0] pmax;
	logic [10:0] size;
	logic [10:0] fill_inc;
	logic [15:0] remain_dec;
	logic        go;
	logic [15:0] cur_remain;
	logic [10:0] cur_fill;
	logic [12:0] cur_offset;
	logic [7:0]  cur_proto;

	assign in_ready = cmd_ready;
	assign accept   = in_valid & in_ready;

	// largest fragment payload, a multiple of eight
	always_comb begin
		mtu_c = link_mtu;
		if (mtu_c < MTU_MIN) mtu_c = MTU_MIN;
		if (mtu_c > MTU_MAX) mtu_c = MTU_MAX;
		pmax = (mtu_c - 11'(IP_HDR_LEN)) & ~11'd7;
	end

	// classify the beat and compute the next segment state
	always_comb begin
		remain_d   = remain_q;
		fill_d     = fill_q;
		offset_d   = offset_q;
		proto_d    = proto_q;
		drop_d     = drop_q;
		fsize_d    = fsize_q;
		produce    = 1'b0;
		go         = 1'b0;
		cur_remain = remain_q;
		cur_fill   = fill_q;
		cur_offset = offset_q;
		cur_proto  = proto_q;
		size       = fsize_q;
		fill_inc   = '0;
		remain_dec = '0;
		cmd        = '0;
		cmd.data   = payload_byte;
		if (first_byte) begin
			fill_d   = '0;
			offset_d = '0;
			fsize_d  = '0;
			drop_d   = 1'b0;
			if (segment_length > LEN_LIMIT) begin
				remain_d = segment_length - 16'd1;
				drop_d   = (segment_length != 16'd1);
				produce  = 1'b1;
				cmd.err  = 1'b1;
				cmd.data = '0;
			end else begin
				remain_d = segment_length;
				if (segment_length != 16'd0) begin
					proto_d    = upper_protocol;
					go         = 1'b1;
					cur_remain = segment_length;
					cur_fill   = '0;
					cur_offset = '0;
					cur_proto  = upper_protocol;
				end
			end
		end else if (remain_q != 16'd0) begin
			if (drop_q) begin
				remain_d = remain_q - 16'd1;
				if (remain_q == 16'd1) drop_d = 1'b0;
			end else begin
				go = 1'b1;
			end
		end

		if (go) begin
			produce = 1'b1;
			if (cur_fill == 11'd0) begin
				size    = (cur_remain < {5'd0, pmax}) ? cur_remain[10:0] : pmax;
				fsize_d = size;
				cmd.hdr = 1'b1;
				cmd.mf  = (cur_remain > {5'd0, size});
			end
			fill_inc   = cur_fill + 11'd1;
			remain_dec = cur_remain - 16'd1;
			remain_d   = remain_dec;
			cmd.size   = size;
			cmd.offset = cur_offset;
			cmd.proto  = cur_proto;
			if (fill_inc >= size || remain_dec == 16'd0) begin
				cmd.last = 1'b1;
				offset_d = cur_offset + {5'd0, size[10:3]};
				fill_d   = '0;
			end else begin
				fill_d = fill_inc;
			end
		end
	end

	assign cmd_valid = accept & produce;

	// segment state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			remain_q <= '0;
			fill_q   <= '0;
			offset_q <= '0;
			proto_q  <= '0;
			drop_q   <= 1'b0;
			fsize_q  <= '0;
		end else if (accept) begin
			remain_q <= remain_d;
			fill_q   <= fill_d;
			offset_q <= offset_d;
			proto_q  <= proto_d;
			drop_q   <= drop_d;
			fsize_q  <= fsize_d;
		end
	end
endmodule

// ===== sv/ipfef_fifo.sv =====
// short queue of work items between front and back
// depends on ipfef_pkg
`timescale 1ns / 1ps
module ipfef_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  ipfef_pkg::cmd_t push_data,
	output logic            not_full,
	input  logic            pop,
	output logic            not_empty,
	output ipfef_pkg::cmd_t pop_data
);
	import ipfef_pkg::*;

	cmd_t                 mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   wr_q;
	logic [FIFO_AW-1:0]   rd_q;
	logic [FIFO_AW:0]     count_q;

	assign not_full  = (count_q != (FIFO_AW+1)'(FIFO_DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data  = mem_q[rd_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop)  rd_q <= rd_q + 1'b1;
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end
endmodule

// ===== sv/ipfef_back.sv =====
// back end: header sequencer, checksum and output register
// depends on ipfef_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "ipv4_fragmenter_ethernet_framer_defines.svh"
module ipfef_back (
	input  logic                clk,
	input  logic                arst_n,
	input  ipfef_pkg::hdr_cfg_t hcfg,
	input  logic                q_valid,
	input  ipfef_pkg::cmd_t     q_data,
	output logic                q_pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [7:0]          frame_byte,
	output logic                frame_end,
	output logic                too_long
);
	import ipfef_pkg::*;

	cmd_t                 cur_q;
	logic                 active_q;
	logic                 hdr_q;
	logic [HDR_IDX_W-1:0] idx_q;
	logic [19:0]          sum_q;
	logic                 ovalid_q;
	logic [7:0]           obyte_q;
	logic                 oend_q;
	logic                 oerr_q;

	logic                 can_load;
	logic                 finishing;
	logic [HDR_IDX_W-1:0] widx_full;
	logic [3:0]           widx;
	logic [15:0]          word;
	logic [15:0]          sum_word;
	logic [15:0]          cksum;
	logic [7:0]           hbyte;
	logic [5:0]           boff;

	assign can_load  = !ovalid_q || out_ready;
	assign finishing = can_load && active_q && !hdr_q;
	assign q_pop     = q_valid && (!active_q || finishing);
	assign cksum     = ~sum_q[15:0];

	// ip header word selection; checksum word is zero while summing
	always_comb begin
		widx_full = idx_q - HDR_IDX_W'(14);
		unique case (1'b1)
			(idx_q < HDR_IDX_W'(10)): widx = idx_q[3:0];
			default:                  widx = widx_full[4:1];
		endcase
		unique case (widx)
			4'd0:    word = 16'h4500;
			4'd1:    word = {5'd0, cur_q.size} + 16'(IP_HDR_LEN);
			4'd2:    word = hcfg.ident;
			4'd3:    word = {2'b00, cur_q.mf, cur_q.offset};
			4'd4:    word = {TTL_VALUE, cur_q.proto};
			4'd5:    word = '0;
			4'd6:    word = hcfg.src_ip[31:16];
			4'd7:    word = hcfg.src_ip[15:0];
			4'd8:    word = hcfg.dest_ip[31:16];
			4'd9:    word = hcfg.dest_ip[15:0];
			default: word = '0;
		endcase
		sum_word = word;
		if (widx == 4'd5 && idx_q >= HDR_IDX_W'(14)) word = cksum;
	end

	// header byte at the current position
	always_comb begin
		boff = '0;
		priority if (idx_q < HDR_IDX_W'(6)) begin
			boff  = 6'(6'd40 - {idx_q[2:0], 3'b000});
			hbyte = hcfg.dest_mac[boff +: 8];
		end else if (idx_q < HDR_IDX_W'(12)) begin
			boff  = 6'(6'd40 - {3'(idx_q - HDR_IDX_W'(6)), 3'b000});
			hbyte = hcfg.src_mac[boff +: 8];
		end else if (idx_q == HDR_IDX_W'(12)) begin
			hbyte = 8'h08;
		end else if (idx_q == HDR_IDX_W'(13)) begin
			hbyte = 8'h00;
		end else begin
			hbyte = widx_full[0] ? word[7:0] : word[15:8];
		end
	end

	// sequencer and checksum accumulation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			hdr_q    <= 1'b0;
			idx_q    <= '0;
		end else begin
			if (q_pop) begin
				active_q <= 1'b1;
				hdr_q    <= q_data.hdr;
				idx_q    <= '0;
			end else if (finishing) begin
				active_q <= 1'b0;
			end else if (can_load && active_q && hdr_q) begin
				if (idx_q == HDR_IDX_W'(HDR_TOTAL - 1)) hdr_q <= 1'b0;
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) cur_q <= q_data;
		if (can_load && active_q && hdr_q) begin
			priority if (idx_q == '0)
				sum_q <= {4'd0, sum_word};
			else if (idx_q < HDR_IDX_W'(10))
				sum_q <= sum_q + {4'd0, sum_word};
			else if (idx_q < HDR_IDX_W'(12))
				sum_q <= {4'd0, sum_q[15:0]} + {16'd0, sum_q[19:16]};
			else
				sum_q <= sum_q;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (can_load) begin
			ovalid_q <= active_q;
		end
	end

	always_ff @(posedge clk) begin
		if (can_load && active_q) begin
			if (hdr_q) begin
				obyte_q <= hbyte;
				oend_q  <= 1'b0;
				oerr_q  <= 1'b0;
			end else begin
				obyte_q <= cur_q.data;
				oend_q  <= cur_q.last;
				oerr_q  <= cur_q.err;
			end
		end
	end

	assign out_valid  = ovalid_q;
	assign frame_byte = obyte_q;
	assign frame_end  = oend_q;
	assign too_long   = oerr_q;

	`IPFEF_ASSERT(a_idx_range, clk, arst_n, (active_q && hdr_q) |-> (idx_q < HDR_IDX_W'(HDR_TOTAL)))
	`IPFEF_ASSERT(a_err_no_end, clk, arst_n, (ovalid_q && oerr_q) |-> !oend_q)
	`IPFEF_ASSERT_NEXT(a_pop_starts, clk, arst_n, q_pop, active_q)
endmodule

// ===== tb/sv/ipfef_frame_checker.sv =====
// checker for the ipv4 fragmenter and ethernet framer: predicts frame beats and compares
// depends on ipfef_pkg; watches the input, output and configuration channels
`timescale 1ns / 1ps
module ipfef_frame_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,  // payload_byte, segment_length, upper_protocol
	input  logic        s_tuser,  // first_byte
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [7:0]  m_tdata,  // frame_byte
	input  logic        m_tlast,
	input  logic        m_tuser,  // too_long
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [47:0] cfg_data,
	output int          fail_count,
	output int          pending_beats
);
	import ipfef_pkg::*;

	typedef struct packed {
		logic [7:0] byte_val;
		logic       frame_end;
		logic       too_long;
	} frame_beat_t;

	frame_beat_t expected_beats[$];

	// local copy of the registers
	logic [47:0] dmac, smac;
	logic [31:0] sip, dip;
	logic [10:0] mtu;
	logic [15:0] ident;

	// segment state
	logic [15:0] remaining;
	logic [10:0] fill, frag_size;
	logic [12:0] offset;
	logic [7:0]  proto;
	logic        dropping;

	assign pending_beats = expected_beats.size();

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	function automatic logic [10:0] payload_limit();
		logic [10:0] m;
		m = mtu;
		if (m < MTU_MIN) m = MTU_MIN;
		if (m > MTU_MAX) m = MTU_MAX;
		return ((m - 11'd20) >> 3) << 3;
	endfunction

	task automatic push_beat(input logic [7:0] b, input logic e, input logic err);
		frame_beat_t fb;
		fb.byte_val = b;
		fb.frame_end = e;
		fb.too_long = err;
		expected_beats.push_back(fb);
	endtask

	// ethernet and ipv4 header with checksum
	task automatic push_frame_header(input logic [10:0] size, input logic mf);
		logic [15:0] w[10];
		logic [31:0] sum;
		w[0] = 16'h4500;
		w[1] = 16'(size) + 16'd20;
		w[2] = ident;
		w[3] = {2'b0, mf, offset};
		w[4] = {TTL_VALUE, proto};
		w[5] = 16'h0;
		w[6] = sip[31:16];
		w[7] = sip[15:0];
		w[8] = dip[31:16];
		w[9] = dip[15:0];
		sum = 0;
		for (int i = 0; i < 10; i++) sum += w[i];
		while (sum[31:16] != 0) sum = sum[15:0] + sum[31:16];
		w[5] = ~sum[15:0];
		for (int i = 0; i < 6; i++) push_beat(dmac[47 - 8 * i -: 8], 1'b0, 1'b0);
		for (int i = 0; i < 6; i++) push_beat(smac[47 - 8 * i -: 8], 1'b0, 1'b0);
		push_beat(8'h08, 1'b0, 1'b0);
		push_beat(8'h00, 1'b0, 1'b0);
		for (int i = 0; i < 10; i++) begin
			push_beat(w[i][15:8], 1'b0, 1'b0);
			push_beat(w[i][7:0], 1'b0, 1'b0);
		end
	endtask

	task automatic predict_segment_byte(input logic [7:0] b, input logic first,
			input logic [15:0] len, input logic [7:0] pr);
		logic [10:0] lim, size;
		if (first) begin
			fill = 0;
			offset = 0;
			frag_size = 0;
			dropping = 0;
			if (32'(len) + 32'd20 > 32'(MAX_DATAGRAM)) begin
				remaining = len - 16'd1;
				dropping = remaining != 0;
				push_beat(8'h00, 1'b0, 1'b1);
				return;
			end
			remaining = len;
			if (len == 0) return;
			proto = pr;
		end else begin
			if (remaining == 0) return;
			if (dropping) begin
				remaining--;
				if (remaining == 0) dropping = 0;
				return;
			end
		end
		if (fill == 0) begin
			lim = payload_limit();
			size = (remaining < 16'(lim)) ? remaining[10:0] : lim;
			frag_size = size;
			push_frame_header(size, remaining > 16'(size));
		end
		fill++;
		remaining--;
		if (fill >= frag_size || remaining == 0) begin
			push_beat(b, 1'b1, 1'b0);
			offset += 13'(frag_size >> 3);
			fill = 0;
		end else begin
			push_beat(b, 1'b0, 1'b0);
		end
	endtask

	// track accepted beats on all three channels
	always @(posedge clk or negedge arst_n) begin
		frame_beat_t want;
		if (!arst_n) begin
			fail_count = 0;
			expected_beats.delete();
			dmac = 0; smac = 0; sip = 0; dip = 0; mtu = 11'd1500; ident = 16'd1;
			remaining = 0; fill = 0; frag_size = 0; offset = 0; proto = 0; dropping = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_DEST_MAC: dmac = cfg_data;
					REG_SRC_MAC:  smac = cfg_data;
					REG_SRC_IP:   sip = cfg_data[31:0];
					REG_DEST_IP:  dip = cfg_data[31:0];
					REG_MTU:      mtu = cfg_data[10:0];
					REG_IDENT:    ident = cfg_data[15:0];
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				if (expected_beats.size() == 0) begin
					report_mismatch("unexpected beat", m_tdata, 0);
				end else begin
					want = expected_beats.pop_front();
					if (m_tuser !== want.too_long)
						report_mismatch("too_long", m_tuser, want.too_long);
					if (!want.too_long && m_tdata !== want.byte_val)
						report_mismatch("frame_byte", m_tdata, want.byte_val);
					if (m_tlast !== want.frame_end)
						report_mismatch("frame_end", m_tlast, want.frame_end);
				end
			end
			if (s_tvalid && s_tready)
				predict_segment_byte(s_tdata[7:0], s_tuser, s_tdata[23:8], s_tdata[31:24]);
		end
	end
endmodule

// ===== tb/sv/ipv4_fragmenter_ethernet_framer_tb.sv =====
// testbench top: clock, reset, stimulus, idling phases and verdict
// depends on ipfef_pkg, ipv4_fragmenter_ethernet_framer and ipfef_frame_checker
`timescale 1ns / 1ps
module ipv4_fragmenter_ethernet_framer_tb;
	import ipfef_pkg::*;

	logic        clk, arst_n;
	logic        s_tvalid, s_tready, s_tuser;
	logic [31:0] s_tdata;  // payload_byte, segment_length, upper_protocol
	logic        m_tvalid, m_tready, m_tlast, m_tuser;
	logic [7:0]  m_tdata;  // frame_byte
	logic        cfg_valid, cfg_ready;
	logic [2:0]  cfg_index;
	logic [47:0] cfg_data;
	int          fail_count, pending_beats;
	int          send_idle_pct, recv_stall_pct;
	logic        hold_off;
	longint      cycles;

	localparam longint CYCLE_LIMIT = 2000000;

	ipv4_fragmenter_ethernet_framer dut (.*);

	ipfef_frame_checker checker_i (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// receiver: random stalls plus a long hold-off when asked
	always @(negedge clk) begin
		if (hold_off) m_tready <= 1'b0;
		else m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [47:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// one segment byte; valid stays high between back-to-back beats
	task automatic send_beat(input logic [7:0] b, input logic first,
			input logic [15:0] len, input logic [7:0] pr);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {pr, len, b};
		s_tuser <= first;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic send_segment(input int len, input int sent_count);
		logic [7:0] pr;
		pr = 8'($urandom);
		for (int i = 0; i < sent_count; i++)
			send_beat(8'($urandom), i == 0, (i == 0) ? 16'(len) : 16'($urandom), pr);
	endtask

	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_beats != 0) @(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	task automatic config_all(input logic [10:0] mtu);
		write_reg(REG_DEST_MAC, 48'({$urandom, $urandom}));
		write_reg(REG_SRC_MAC, 48'({$urandom, $urandom}));
		write_reg(REG_SRC_IP, 48'($urandom));
		write_reg(REG_DEST_IP, 48'($urandom));
		write_reg(REG_MTU, 48'(mtu));
		write_reg(REG_IDENT, 48'($urandom));
	endtask

	initial begin
		int len;
		arst_n = 0;
		s_tvalid = 0; s_tdata = 0; s_tuser = 0;
		m_tready = 0; cfg_valid = 0; cfg_index = 0; cfg_data = 0;
		send_idle_pct = 0; recv_stall_pct = 0; hold_off = 0; cycles = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: reset registers, small segment, stray and empty cases
		send_segment(5, 5);
		send_beat(8'hff, 1'b0, 16'hffff, 8'hff);
		send_beat(8'h00, 1'b1, 16'd0, 8'h00);
		drain();
		write_reg(REG_DEST_MAC, 48'hffff_ffff_ffff);
		write_reg(REG_SRC_MAC, 48'h0);
		write_reg(REG_SRC_IP, 48'hffff_ffff);
		write_reg(REG_DEST_IP, 48'h0);
		write_reg(REG_MTU, 48'd68);
		write_reg(REG_IDENT, 48'hffff);
		// fragments of 48 with a short tail, an oversize segment, an interrupted one
		send_segment(52, 52);
		send_segment(65516, 3);
		send_beat(8'h5a, 1'b0, 16'h0, 8'h0);
		send_segment(60, 8);
		send_segment(1, 1);
		drain();
		write_reg(REG_MTU, 48'd0);
		send_segment(4, 4);
		send_segment(65515, 1);
		drain();
		write_reg(REG_MTU, 48'h7ff);
		send_segment(3, 3);
		drain();

		// random phases with various idling
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 30 : 73) : 0;
			recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 30 : 73) : 0;
			config_all((ph == 0) ? 11'd1500 : 11'(68 + $urandom_range(80)));
			if (ph == 0) begin
				// long receiver hold-off while the sender keeps offering beats
				fork
					begin
						hold_off = 1;
						repeat (300) @(posedge clk);
						hold_off = 0;
					end
				join_none
				send_segment(8, 8);
			end
			for (int s = 0; s < 3; s++) begin
				len = ($urandom_range(9) == 0) ? int'($urandom_range(65535, 65516))
					: int'($urandom_range(1, 3));
				if (len > 65515) send_segment(len, $urandom_range(1, 3));
				else if ($urandom_range(7) == 0) send_segment(len, $urandom_range(1, len));
				else send_segment(len, len);
			end
			drain();
		end

		if (fail_count == 0) $display("Simulation PASSED");
		else $display("Simulation FAILED");
		$finish;
	end
endmodule
